// File: src/wsdf_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsdf_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [3:0] EXT_BYTES_16 = 4'd2;
   localparam logic [3:0] EXT_BYTES_64 = 4'd8;
   localparam logic [3:0] KEY_BYTES = 4'd4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  raw_byte;
      logic [7:0]  key_byte;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] length;
      logic        last;
   } wsdf_rec_type;

endpackage

// File: src/wsdf_front.sv
// Header parser that classifies each stream byte and queues result records.
module wsdf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_data_byte,
   input  logic                  queue_full,
   output logic                  push,
   output wsdf_pkg::wsdf_rec_type push_rec
);
   import wsdf_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [63:0] pay_ff, pay_in;
   logic        accept;
   logic        len_known;
   logic        hdr_done;
   logic        zero_len;
   logic [7:0]  key_byte;

   assign accept = req_valid && !queue_full;

   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      len_in     = len_ff;
      key_in     = key_ff;
      hdr_cnt_in = hdr_cnt_ff;
      pay_in     = pay_ff;
      len_known  = 1'b0;
      hdr_done   = 1'b0;
      zero_len   = 1'b0;
      push       = 1'b0;
      push_rec   = '0;
      case (pay_ff[1:0])
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = req_data_byte[7];
               opcode_in = req_data_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = req_data_byte[7];
               key_in  = '0;
               if (req_data_byte[6:0] < LEN_CODE_16) begin
                  len_in    = {57'd0, req_data_byte[6:0]};
                  len_known = 1'b1;
               end else begin
                  len_in     = '0;
                  hdr_cnt_in = (req_data_byte[6:0] == LEN_CODE_16) ? EXT_BYTES_16
                                                                  : EXT_BYTES_64;
                  phase_in   = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               len_in     = {len_ff[55:0], req_data_byte};
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               if (hdr_cnt_in == 4'd0) begin
                  len_known = 1'b1;
               end
            end
            PH_KEY: begin
               key_in     = {key_ff[23:0], req_data_byte};
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               if (hdr_cnt_in == 4'd0) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               pay_in            = pay_ff + 64'd1;
               push              = 1'b1;
               push_rec.kind     = KIND_PAYLOAD;
               push_rec.raw_byte = req_data_byte;
               push_rec.key_byte = key_byte;
               push_rec.last     = (pay_in == len_ff);
               if (push_rec.last) begin
                  pay_in   = '0;
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               fin_in    = req_data_byte[7];
               opcode_in = req_data_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase
         if (len_known) begin
            if (mask_in) begin
               hdr_cnt_in = KEY_BYTES;
               phase_in   = PH_KEY;
            end else begin
               hdr_done = 1'b1;
            end
         end
         if (hdr_done) begin
            zero_len      = (len_in == 64'd0);
            push          = 1'b1;
            push_rec.kind = KIND_HEADER;
            push_rec.last = zero_len;
            pay_in        = '0;
            phase_in      = zero_len ? PH_HDR0 : PH_PAYLOAD;
         end
      end
      push_rec.fin    = fin_in;
      push_rec.opcode = opcode_in;
      push_rec.masked = mask_in;
      push_rec.length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fin_ff     <= 1'b0;
         opcode_ff  <= '0;
         mask_ff    <= 1'b0;
         len_ff     <= '0;
         key_ff     <= '0;
         hdr_cnt_ff <= '0;
         pay_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         mask_ff    <= mask_in;
         len_ff     <= len_in;
         key_ff     <= key_in;
         hdr_cnt_ff <= hdr_cnt_in;
         pay_ff     <= pay_in;
      end
   end

   a_payload_in_phase: assert property (@(posedge clock) disable iff (reset)
      (push && push_rec.kind == KIND_PAYLOAD) |-> (phase_ff == PH_PAYLOAD))
      else $error("Payload beat produced outside the payload phase.");

   a_header_opens_payload: assert property (@(posedge clock) disable iff (reset)
      (push && push_rec.kind == KIND_HEADER && !push_rec.last) |=> (phase_ff == PH_PAYLOAD))
      else $error("Nonempty frame header did not open the payload phase.");

   a_header_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXTLEN || phase_ff == PH_KEY) |-> (hdr_cnt_ff != 4'd0))
      else $error("Header byte counter is zero inside the header.");

endmodule

// File: src/wsdf_queue.sv
// Short register queue between the parser and the output stage.
module wsdf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsdf_pkg::wsdf_rec_type push_rec,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output wsdf_pkg::wsdf_rec_type pop_rec
);
   import wsdf_pkg::*;

   wsdf_rec_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_rec   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("Record pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("Record popped from an empty queue.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("Queue occupancy exceeds its depth.");

endmodule

// File: src/wsdf_back.sv
// Output stage that unmasks payload bytes and holds the result beat.
module wsdf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rec_valid,
   input  wsdf_pkg::wsdf_rec_type rec,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_data,
   output logic                   rsp_fin,
   output logic [3:0]             rsp_opcode,
   output logic                   rsp_masked,
   output logic [63:0]            rsp_payload_length,
   output logic                   rsp_last
);
   import wsdf_pkg::*;

   logic        valid_ff;
   logic        kind_ff;
   logic [7:0]  data_ff;
   logic        fin_ff;
   logic [3:0]  opcode_ff;
   logic        masked_ff;
   logic [63:0] length_ff;
   logic        last_ff;
   logic [7:0]  data_in;

   assign pop     = rec_valid && (!valid_ff || !rsp_stall);
   assign data_in = (rec.kind == KIND_PAYLOAD) ? (rec.raw_byte ^ rec.key_byte) : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= rec.kind;
         data_ff   <= data_in;
         fin_ff    <= rec.fin;
         opcode_ff <= rec.opcode;
         masked_ff <= rec.masked;
         length_ff <= rec.length;
         last_ff   <= rec.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_data           = data_ff;
   assign rsp_fin            = fin_ff;
   assign rsp_opcode         = opcode_ff;
   assign rsp_masked         = masked_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_last           = last_ff;

endmodule

// File: src/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer.
//
//   Channel   Ports   Direction   Beat
//   request   req_    in          one stream byte
//   response  rsp_    out         one header or unmasked payload result
//
// A byte can be accepted every cycle while req_stall is low.
// A result appears on rsp_ after its byte is accepted, passing through the queue and
// the output register. Header bytes before the final one give no result.
// Reset is synchronous and active high and returns the parser to the first header byte.
// req_stall rises only when the two-entry queue is full behind a stalled output.
module websocket_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data,
   output logic        rsp_fin,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_masked,
   output logic [63:0] rsp_payload_length,
   output logic        rsp_last
);
   import wsdf_pkg::*;

   logic         push;
   wsdf_rec_type push_rec;
   logic         pop;
   logic         queue_full;
   logic         queue_not_empty;
   wsdf_rec_type pop_rec;

   assign req_stall = queue_full;

   wsdf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_rec      (push_rec)
   );

   wsdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop_rec   (pop_rec)
   );

   wsdf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .rec_valid          (queue_not_empty),
      .rec                (pop_rec),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data           (rsp_data),
      .rsp_fin            (rsp_fin),
      .rsp_opcode         (rsp_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last           (rsp_last)
   );

endmodule
